// ----- hdl/weekly_alarm_table_matcher_core_macros.svh -----
// Assertion helpers for the asserting file, the core top.
`ifndef WEEKLY_ALARM_TABLE_MATCHER_CORE_MACROS_SVH
`define WEEKLY_ALARM_TABLE_MATCHER_CORE_MACROS_SVH

// same-cycle implication
`define WATM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WATM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/watm_pkg.sv -----
`default_nettype none
package watm_pkg;

  localparam int SLOT_COUNT_DEF = 8;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  localparam logic [1:0] STAT_OFF   = 2'd0;
  localparam logic [1:0] STAT_NONE  = 2'd1;
  localparam logic [1:0] STAT_FOUND = 2'd2;

  localparam int KEY_W = 22;
  localparam int POS_W = 14;
  localparam logic [POS_W-1:0] WEEK_MINUTES = 14'd10080;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] slot_index;
    logic       write_enabled;
    logic [2:0] write_weekday;
    logic [4:0] write_hour;
    logic [5:0] write_minute;
    logic       clock_valid;
    logic [9:0] now_year;
    logic [8:0] now_day_of_year;
    logic [2:0] now_weekday;
    logic [4:0] now_hour;
    logic [5:0] now_minute;
  } in_word_t;

  typedef struct packed {
    logic        start_request;
    logic [1:0]  schedule_status;
    logic [2:0]  next_weekday;
    logic [4:0]  next_hour;
    logic [5:0]  next_minute;
    logic [13:0] minutes_until_next;
    logic        read_enabled;
    logic [2:0]  read_weekday;
    logic [4:0]  read_hour;
    logic [5:0]  read_minute;
  } out_word_t;

  typedef struct packed {
    logic       en;
    logic [2:0] wd;
    logic [4:0] hr;
    logic [5:0] mn;
  } slot_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic mem_write;
    logic read_issue;
    logic prep;
    logic walk_issue;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       clock_valid;
    logic       walk_last;
    logic       pipe_busy;
  } sts_t;

endpackage
`default_nettype wire

// ----- hdl/weekly_alarm_table_matcher_core.sv -----
// Channel  Handshake              Payload
// in       in_valid / in_stall    watm_pkg::in_word_t
// out      out_valid / out_stall  watm_pkg::out_word_t
//
// A tick with a valid clock walks the slot table through the single read port of the
// slot store, one slot per cycle.
// Writes, reads and other words go from the decode state straight to the finish state.
// Reset empties the slot table and clears the last trigger key.
// A stalled result waits in the output register while the next word is taken.
`default_nettype none
`include "weekly_alarm_table_matcher_core_macros.svh"
module weekly_alarm_table_matcher_core #(
  parameter int SLOT_COUNT = watm_pkg::SLOT_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  watm_pkg::in_word_t   in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output watm_pkg::out_word_t  out_word
);

  watm_pkg::cmd_t cmd;
  watm_pkg::sts_t sts;

  watm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  watm_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_word  (in_word),
    .cmd      (cmd),
    .sts      (sts),
    .out_word (out_word)
  );

  `WATM_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "word taken while busy")
  `WATM_ASSERT_NOW(a_no_overwrite, cmd.load_out, !out_valid || !out_stall, "result overwritten")
  `WATM_ASSERT_NOW(a_start_has_slot, out_valid && out_word.start_request,
    out_word.schedule_status == watm_pkg::STAT_FOUND, "start without scheduled slot")
  `WATM_ASSERT_NOW(a_found_dist, out_valid && out_word.schedule_status == watm_pkg::STAT_FOUND,
    out_word.minutes_until_next != '0 && out_word.minutes_until_next <= watm_pkg::WEEK_MINUTES,
    "distance out of week")

endmodule
`default_nettype wire

// ----- hdl/watm_ctrl.sv -----
`default_nettype none
module watm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  watm_pkg::sts_t    sts,
  output watm_pkg::cmd_t    cmd
);

  watm_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= watm_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      watm_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = watm_pkg::ST_DECODE;
        end
      end
      watm_pkg::ST_DECODE: begin
        state_next = watm_pkg::ST_FINISH;
        case (sts.action)
          watm_pkg::ACT_WRITE: cmd.mem_write = 1'b1;
          watm_pkg::ACT_READ:  cmd.read_issue = 1'b1;
          watm_pkg::ACT_TICK: begin
            if (sts.clock_valid) begin
              cmd.prep   = 1'b1;
              state_next = watm_pkg::ST_WALK;
            end
          end
          default: ;
        endcase
      end
      watm_pkg::ST_WALK: begin
        cmd.walk_issue = 1'b1;
        if (sts.walk_last) begin
          state_next = watm_pkg::ST_DRAIN;
        end
      end
      watm_pkg::ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_next = watm_pkg::ST_FINISH;
        end
      end
      watm_pkg::ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          cmd.load_out = 1'b1;
          state_next   = watm_pkg::ST_IDLE;
        end
      end
      default: state_next = watm_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/watm_dp.sv -----
`default_nettype none
module watm_dp #(
  parameter int SLOT_COUNT = watm_pkg::SLOT_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  watm_pkg::in_word_t   in_word,
  input  watm_pkg::cmd_t       cmd,
  output watm_pkg::sts_t       sts,
  output watm_pkg::out_word_t  out_word
);

  localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int KW = watm_pkg::KEY_W;
  localparam int PW = watm_pkg::POS_W;
  localparam logic [8:0] SLOT_LIM = 9'(SLOT_COUNT);
  localparam logic [AW-1:0] LAST_ADDR = AW'(SLOT_COUNT - 1);

  function automatic logic [PW-1:0] week_pos(input logic [2:0] wd, input logic [4:0] hr,
                                             input logic [5:0] mn);
    logic [2:0] w;
    logic [4:0] h;
    logic [5:0] m;
    w = (wd == 3'd7) ? 3'd0 : wd;
    h = (hr >= 5'd24) ? (hr - 5'd24) : hr;
    m = (mn >= 6'd60) ? (mn - 6'd60) : mn;
    return PW'(w) * PW'(1440) + PW'(h) * PW'(60) + PW'(m);
  endfunction

  watm_pkg::in_word_t item;
  watm_pkg::slot_t    mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] vld;
  watm_pkg::slot_t    rd_slot;
  logic               rd_hit;
  watm_pkg::slot_t    slot_q;
  logic               in_range;
  logic [AW-1:0]      req_addr;
  logic [AW-1:0]      raddr;
  logic [AW-1:0]      cnt;
  logic               wr_en;
  logic               rd_en;
  logic               v1;
  logic               v2;
  logic [11:0]        year_sum;
  logic [KW-1:0]      ka;
  logic [KW-1:0]      kb;
  logic [KW-1:0]      key;
  logic [KW-1:0]      last_key;
  logic [PW-1:0]      now_pos;
  logic               s1_en;
  logic               s1_eq;
  logic [PW-1:0]      s1_pos;
  logic [2:0]         s1_wd;
  logic [4:0]         s1_hr;
  logic [5:0]         s1_mn;
  logic [PW:0]        delta_wide;
  logic [PW-1:0]      delta;
  logic               found;
  logic               start;
  logic [PW-1:0]      best;
  logic [2:0]         nwd;
  logic [4:0]         nhr;
  logic [5:0]         nmn;
  watm_pkg::out_word_t res;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= in_word;
    end
  end

  assign in_range = {1'b0, item.slot_index} < SLOT_LIM;
  assign req_addr = item.slot_index[AW-1:0];
  assign wr_en    = cmd.mem_write && in_range;
  assign rd_en    = (cmd.read_issue && in_range) || cmd.walk_issue;
  assign raddr    = cmd.walk_issue ? cnt : req_addr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[req_addr] <= {item.write_enabled, item.write_weekday,
                        item.write_hour, item.write_minute};
    end
    if (rd_en) begin
      rd_slot <= mem[raddr];
      rd_hit  <= vld[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[req_addr] <= 1'b1;
    end
  end

  assign slot_q = rd_hit ? rd_slot : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.walk_issue;
      v2 <= v1;
    end
    if (cmd.prep) begin
      cnt <= '0;
    end else if (cmd.walk_issue) begin
      cnt <= cnt + 1'b1;
    end
  end

  assign year_sum = 12'(item.now_year) + 12'd1900;

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      ka      <= KW'(year_sum) * KW'(1000);
      kb      <= KW'(item.now_day_of_year) * KW'(1440) + KW'(item.now_hour) * KW'(60)
                 + KW'(item.now_minute);
      now_pos <= week_pos(item.now_weekday, item.now_hour, item.now_minute);
    end
  end

  assign key = ka + kb;

  always_ff @(posedge clk) begin
    s1_en  <= slot_q.en;
    s1_eq  <= (slot_q.wd == item.now_weekday) && (slot_q.hr == item.now_hour)
              && (slot_q.mn == item.now_minute);
    s1_pos <= week_pos(slot_q.wd, slot_q.hr, slot_q.mn);
    s1_wd  <= (slot_q.wd == 3'd7) ? 3'd0 : slot_q.wd;
    s1_hr  <= (slot_q.hr >= 5'd24) ? (slot_q.hr - 5'd24) : slot_q.hr;
    s1_mn  <= (slot_q.mn >= 6'd60) ? (slot_q.mn - 6'd60) : slot_q.mn;
  end

  assign delta_wide = (s1_pos > now_pos) ? ({1'b0, s1_pos} - {1'b0, now_pos})
                    : ({1'b0, s1_pos} + {1'b0, watm_pkg::WEEK_MINUTES} - {1'b0, now_pos});
  assign delta = delta_wide[PW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      last_key <= '0;
      found    <= 1'b0;
      start    <= 1'b0;
      best     <= '0;
      nwd      <= '0;
      nhr      <= '0;
      nmn      <= '0;
    end else if (cmd.prep) begin
      found <= 1'b0;
      start <= 1'b0;
      best  <= '0;
      nwd   <= '0;
      nhr   <= '0;
      nmn   <= '0;
    end else if (v2 && s1_en) begin
      if (s1_eq && (key != last_key)) begin
        last_key <= key;
        start    <= 1'b1;
      end
      if (!found || (delta < best)) begin
        found <= 1'b1;
        best  <= delta;
        nwd   <= s1_wd;
        nhr   <= s1_hr;
        nmn   <= s1_mn;
      end
    end
  end

  always_comb begin
    res = '0;
    case (item.action)
      watm_pkg::ACT_READ: begin
        if (in_range) begin
          res.read_enabled = slot_q.en;
          res.read_weekday = slot_q.wd;
          res.read_hour    = slot_q.hr;
          res.read_minute  = slot_q.mn;
        end
      end
      watm_pkg::ACT_TICK: begin
        if (item.clock_valid) begin
          res.start_request      = start;
          res.schedule_status    = found ? watm_pkg::STAT_FOUND : watm_pkg::STAT_NONE;
          res.next_weekday       = nwd;
          res.next_hour          = nhr;
          res.next_minute        = nmn;
          res.minutes_until_next = best;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_word <= res;
    end
  end

  assign sts.action      = item.action;
  assign sts.clock_valid = item.clock_valid;
  assign sts.walk_last   = (cnt == LAST_ADDR);
  assign sts.pipe_busy   = v1 || v2;

endmodule
`default_nettype wire

// ----- sim/weekly_alarm_table_matcher_checker.sv -----
`timescale 1ns / 1ps
module weekly_alarm_table_matcher_checker #(
  parameter int SLOT_COUNT = watm_pkg::SLOT_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  watm_pkg::in_word_t  in_word,
  input  logic                out_valid,
  input  logic                out_stall,
  input  watm_pkg::out_word_t out_word,
  input  logic                wrap_up,
  output int                  failures,
  output int                  waiting
);
  import watm_pkg::*;

  localparam int WEEK_SPAN = 7 * 1440;
  localparam int SHOWN_MAX = 200;

  slot_t       slot_table [SLOT_COUNT];
  logic [31:0] fired_key;
  out_word_t   due_words [$];

  initial begin
    failures = 0;
    waiting = 0;
  end

  task automatic note_failure(input string msg);
    if (failures < SHOWN_MAX) $display("%0t mismatch:%s", $time, msg);
    failures++;
  endtask

  function automatic int week_offset(input logic [2:0] wd, input logic [4:0] hr,
                                     input logic [5:0] mn);
    return (int'(wd) % 7) * 1440 + (int'(hr) % 24) * 60 + int'(mn) % 60;
  endfunction

  function automatic string field_diff(input string name, input logic [31:0] got,
                                       input logic [31:0] want);
    if (got !== want) return $sformatf(" %s got %0d want %0d", name, got, want);
    return "";
  endfunction

  function automatic out_word_t alarm_response(input in_word_t w);
    out_word_t   r;
    slot_t       s;
    logic [31:0] key;
    int          now_pos, pos, delta, best, i;
    bit          found;
    r = '0;
    r.schedule_status = STAT_OFF;
    found = 1'b0;
    best = 0;
    case (w.action)
      ACT_WRITE: begin
        if (w.slot_index < SLOT_COUNT)
          slot_table[w.slot_index] = {w.write_enabled, w.write_weekday, w.write_hour,
                                      w.write_minute};
      end
      ACT_READ: begin
        if (w.slot_index < SLOT_COUNT) begin
          s = slot_table[w.slot_index];
          r.read_enabled = s.en;
          r.read_weekday = s.wd;
          r.read_hour = s.hr;
          r.read_minute = s.mn;
        end
      end
      ACT_TICK: begin
        if (w.clock_valid) begin
          key = (32'(w.now_year) + 32'd1900) * 32'd1000
              + 32'(w.now_day_of_year) * 32'd1440
              + 32'(w.now_hour) * 32'd60 + 32'(w.now_minute);
          now_pos = week_offset(w.now_weekday, w.now_hour, w.now_minute);
          for (i = 0; i < SLOT_COUNT; i++) begin
            s = slot_table[i];
            if (s.en) begin
              if (s.wd == w.now_weekday && s.hr == w.now_hour && s.mn == w.now_minute &&
                  key != fired_key) begin
                fired_key = key;
                r.start_request = 1'b1;
              end
              pos = week_offset(s.wd, s.hr, s.mn);
              delta = (pos > now_pos) ? pos - now_pos : pos + WEEK_SPAN - now_pos;
              if (!found || delta < best) begin
                found = 1'b1;
                best = delta;
                r.next_weekday = 3'(int'(s.wd) % 7);
                r.next_hour = 5'(int'(s.hr) % 24);
                r.next_minute = 6'(int'(s.mn) % 60);
              end
            end
          end
          r.schedule_status = found ? STAT_FOUND : STAT_NONE;
          r.minutes_until_next = found ? 14'(best) : 14'd0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : watch
    out_word_t want;
    string     msg;
    int        k;
    if (rst) begin
      for (k = 0; k < SLOT_COUNT; k++) slot_table[k] = '0;
      fired_key = '0;
      due_words.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (due_words.size() == 0) begin
          note_failure(" result word with none expected");
        end else begin
          want = due_words.pop_front();
          msg = {field_diff("start_request", out_word.start_request, want.start_request),
                 field_diff("schedule_status", out_word.schedule_status,
                            want.schedule_status),
                 field_diff("next_weekday", out_word.next_weekday, want.next_weekday),
                 field_diff("next_hour", out_word.next_hour, want.next_hour),
                 field_diff("next_minute", out_word.next_minute, want.next_minute),
                 field_diff("minutes_until_next", out_word.minutes_until_next,
                            want.minutes_until_next),
                 field_diff("read_enabled", out_word.read_enabled, want.read_enabled),
                 field_diff("read_weekday", out_word.read_weekday, want.read_weekday),
                 field_diff("read_hour", out_word.read_hour, want.read_hour),
                 field_diff("read_minute", out_word.read_minute, want.read_minute)};
          if (msg != "") note_failure(msg);
        end
      end
      if (in_valid && !in_stall) due_words.push_back(alarm_response(in_word));
      if (wrap_up && due_words.size() != 0) begin
        note_failure($sformatf(" %0d expected words never came", due_words.size()));
        due_words.delete();
      end
    end
    waiting = due_words.size();
  end

endmodule

// ----- sim/weekly_alarm_table_matcher_core_test.sv -----
`timescale 1ns / 1ps
module weekly_alarm_table_matcher_core_test;
  import watm_pkg::*;

  localparam int SLOTS = SLOT_COUNT_DEF;
  localparam int RANDOM_WORDS = 700;
  localparam int SEGMENT = 100;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam logic [1:0] ACT_SPARE = 2'd3;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  in_word_t  in_word = '0;
  logic      in_stall;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;
  logic      wrap_up = 1'b0;
  int        failures;
  int        waiting;

  int in_gap_odds = 3;
  int out_stall_odds = 4;
  bit calm = 1'b0;
  int stall_left = 0;
  int quiet_cycles = 0;

  logic [13:0] armed [SLOTS] = '{default: '0};
  int yr = 125, yd = 0, wd = 0, hr = 0, mn = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  weekly_alarm_table_matcher_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  weekly_alarm_table_matcher_checker alarm_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .wrap_up   (wrap_up),
    .failures  (failures),
    .waiting   (waiting)
  );

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!rst && !calm && out_stall_odds != 0 &&
                 $urandom_range(0, out_stall_odds - 1) == 0) begin
      stall_left = $urandom_range(0, 16);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_word_t noise_word();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(in_word_t)-1:0];
  endfunction

  function automatic in_word_t slot_word(input logic [1:0] act, input logic [7:0] idx,
                                         input logic en, input logic [2:0] d,
                                         input logic [4:0] h, input logic [5:0] m);
    in_word_t w;
    w = noise_word();
    w.action = act;
    w.slot_index = idx;
    w.write_enabled = en;
    w.write_weekday = d;
    w.write_hour = h;
    w.write_minute = m;
    return w;
  endfunction

  function automatic in_word_t tick_word(input logic ok, input logic [9:0] y,
                                         input logic [8:0] yday, input logic [2:0] d,
                                         input logic [4:0] h, input logic [5:0] m);
    in_word_t w;
    w = noise_word();
    w.action = ACT_TICK;
    w.clock_valid = ok;
    w.now_year = y;
    w.now_day_of_year = yday;
    w.now_weekday = d;
    w.now_hour = h;
    w.now_minute = m;
    return w;
  endfunction

  task automatic push_word(input in_word_t w);
    int gap;
    gap = 0;
    if (in_gap_odds != 0 && $urandom_range(0, in_gap_odds - 1) == 0)
      gap = $urandom_range(1, 17);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_word <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic store_slot(input logic [7:0] idx, input logic en, input logic [2:0] d,
                            input logic [4:0] h, input logic [5:0] m);
    if (idx < SLOTS) armed[idx] = {d, h, m};
    push_word(slot_word(ACT_WRITE, idx, en, d, h, m));
  endtask

  task automatic read_slot(input logic [7:0] idx);
    push_word(slot_word(ACT_READ, idx, $urandom_range(0, 1), $urandom_range(0, 7),
                        $urandom_range(0, 31), $urandom_range(0, 63)));
  endtask

  initial begin
    int          n, sel, idx;
    logic [13:0] pick;
    int          odds_choice [3];
    odds_choice = '{0, 2, 8};
    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    read_slot(8'd0);
    push_word(tick_word(1'b1, 10'd125, 9'd40, 3'd1, 5'd8, 6'd30));
    push_word(tick_word(1'b0, 10'd125, 9'd40, 3'd1, 5'd8, 6'd30));
    push_word(slot_word(ACT_SPARE, 8'd0, 1'b1, 3'd1, 5'd8, 6'd30));
    store_slot(8'd0, 1'b1, 3'd1, 5'd8, 6'd30);
    store_slot(8'd7, 1'b1, 3'd7, 5'd31, 6'd63);
    store_slot(8'd8, 1'b1, 3'd2, 5'd3, 6'd4);
    store_slot(8'd255, 1'b1, 3'd5, 5'd6, 6'd7);
    read_slot(8'd7);
    read_slot(8'd8);
    read_slot(8'd255);
    push_word(tick_word(1'b1, 10'd125, 9'd40, 3'd1, 5'd8, 6'd30));
    push_word(tick_word(1'b1, 10'd125, 9'd40, 3'd1, 5'd8, 6'd30));
    push_word(tick_word(1'b1, 10'd125, 9'd47, 3'd1, 5'd8, 6'd30));
    store_slot(8'd1, 1'b1, 3'd1, 5'd8, 6'd30);
    push_word(tick_word(1'b1, 10'd125, 9'd48, 3'd1, 5'd8, 6'd29));
    store_slot(8'd2, 1'b0, 3'd2, 5'd0, 6'd0);
    push_word(tick_word(1'b1, 10'd125, 9'd49, 3'd2, 5'd0, 6'd0));
    push_word(tick_word(1'b1, 10'd1023, 9'd511, 3'd7, 5'd31, 6'd63));
    push_word(tick_word(1'b1, 10'd0, 9'd0, 3'd0, 5'd0, 6'd0));
    store_slot(8'd3, 1'b1, 3'd7, 5'd31, 6'd63);
    push_word(tick_word(1'b1, 10'd1023, 9'd100, 3'd7, 5'd31, 6'd63));
    store_slot(8'd0, 1'b0, 3'd0, 5'd0, 6'd0);
    read_slot(8'd3);

    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (n % SEGMENT == 0) begin
        calm = (n >= RANDOM_WORDS - SEGMENT);
        in_gap_odds = calm ? 0 : odds_choice[$urandom_range(0, 2)];
        out_stall_odds = calm ? 0 : odds_choice[$urandom_range(0, 2)];
      end
      sel = $urandom_range(0, 99);
      if (sel < 25) begin
        idx = ($urandom_range(0, 99) < 85) ? $urandom_range(0, SLOTS - 1)
                                           : $urandom_range(SLOTS, 255);
        if ($urandom_range(0, 99) < 85)
          store_slot(idx, $urandom_range(0, 3) != 0, $urandom_range(0, 6),
                     $urandom_range(0, 23), $urandom_range(0, 59));
        else
          store_slot(idx, $urandom_range(0, 3) != 0, $urandom_range(0, 7),
                     $urandom_range(0, 31), $urandom_range(0, 63));
      end else if (sel < 45) begin
        read_slot(($urandom_range(0, 9) != 0) ? $urandom_range(0, SLOTS - 1)
                                              : $urandom_range(SLOTS, 255));
      end else if (sel < 95) begin
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
          mn = mn + 1;
          if (mn >= 60) begin
            mn = 0;
            hr = hr + 1;
            if (hr >= 24) begin
              hr = 0;
              wd = (wd + 1) % 7;
              yd = (yd >= 365) ? 0 : yd + 1;
            end
          end
        end else if (sel < 70) begin
          pick = armed[$urandom_range(0, SLOTS - 1)];
          wd = pick[13:11];
          hr = pick[10:6];
          mn = pick[5:0];
        end else if (sel < 80) begin
          // hold the same minute to probe the once-per-minute rule
        end else if (sel < 92) begin
          yd = $urandom_range(0, 365);
          wd = $urandom_range(0, 6);
          hr = $urandom_range(0, 23);
          mn = $urandom_range(0, 59);
        end else begin
          yr = $urandom_range(0, 1023);
          yd = $urandom_range(0, 511);
          wd = $urandom_range(0, 7);
          hr = $urandom_range(0, 31);
          mn = $urandom_range(0, 63);
        end
        if ($urandom_range(0, 19) == 0) yr = $urandom_range(0, 1023);
        push_word(tick_word($urandom_range(0, 9) != 0, yr, yd, wd, hr, mn));
      end else begin
        push_word(slot_word(ACT_SPARE, $urandom_range(0, 255), $urandom_range(0, 1),
                            $urandom_range(0, 7), $urandom_range(0, 31),
                            $urandom_range(0, 63)));
      end
    end

    @(negedge clk) in_valid <= 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    wrap_up <= 1'b1;
    @(negedge clk) wrap_up <= 1'b0;
    @(negedge clk);
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
